// ===== hw/rtl/drle_pkg.sv =====
// shared types, codes and template tables for the data segment rle decoder
package drle_pkg;

  localparam int DEFAULT_SEGMENT_COUNT = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int RUN_W = 6;

  localparam logic [7:0] BYTE_FF = 8'hFF;
  localparam logic [7:0] BYTE_A9 = 8'hA9;
  localparam logic [7:0] BYTE_F0 = 8'hF0;

  localparam logic [7:0] CODE_END = 8'h00;
  localparam logic [7:0] CODE_TMPL_LAST = 8'h04;

  localparam logic [2:0] TMPL_FF_PAIR = 3'd1;
  localparam logic [2:0] TMPL_FF_ONE = 3'd2;

  typedef enum logic [2:0] {
    PH_OFFSET,
    PH_CONTROL,
    PH_LITERAL,
    PH_REPEAT,
    PH_TEMPLATE,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_SEG_END,
    KIND_STREAM_END,
    KIND_BAD
  } kind_t;

  typedef enum logic [1:0] {
    CMD_RUN,
    CMD_END,
    CMD_BAD
  } cmd_op_t;

  // one queued command, the work caused by one input byte
  typedef struct packed {
    cmd_op_t          op;
    logic [31:0]      addr;
    logic [7:0]       data;
    logic [RUN_W-1:0] count;
    logic             alt;
    logic             stream_end;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmd_push_t;

  // number of literal bytes that follow a template code
  function automatic logic [2:0] tmpl_count(input logic [2:0] code);
    logic [2:0] n;
    case (code)
      3'd1: n = 3'd2;
      3'd2: n = 3'd3;
      3'd3: n = 3'd3;
      3'd4: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // byte position of a template literal from the cursor
  function automatic logic [2:0] tmpl_pos(input logic [2:0] code, input logic [1:0] step);
    logic [2:0] p;
    case ({code, step})
      {3'd1, 2'd0}: p = 3'd6;
      {3'd1, 2'd1}: p = 3'd7;
      {3'd2, 2'd0}: p = 3'd5;
      {3'd2, 2'd1}: p = 3'd6;
      {3'd2, 2'd2}: p = 3'd7;
      {3'd3, 2'd0}: p = 3'd4;
      {3'd3, 2'd1}: p = 3'd5;
      {3'd3, 2'd2}: p = 3'd7;
      {3'd4, 2'd0}: p = 3'd3;
      {3'd4, 2'd1}: p = 3'd4;
      {3'd4, 2'd2}: p = 3'd5;
      {3'd4, 2'd3}: p = 3'd7;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/data_segment_rle_decoder.sv =====
// Data segment RLE decoder: takes one compressed byte per transfer and issues
// byte writes plus segment end, stream end and bad code markers. A byte that
// causes no result or one result is taken every cycle; a byte that causes N
// results (a fill or repeat run of up to 33 writes, a template head of up to
// two) keeps the write expander busy for all N, one result per cycle unless
// stalled. The parser runs ahead through a two-entry command queue and stalls
// input only when that queue is full. dest_base is sampled on the fourth
// offset byte of each segment; after the last segment every further byte is
// taken and ignored until reset.
module data_segment_rle_decoder #(
  parameter int SEGMENT_COUNT = drle_pkg::DEFAULT_SEGMENT_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        stream_valid,
  output logic        stream_stall,
  input  logic [7:0]  stream_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [31:0] write_address,
  output logic [7:0]  write_data,
  output logic        last
);
  import drle_pkg::*;

  cmd_push_t cq;
  cmd_t      head;
  logic      head_valid;
  logic      pop;
  logic      full;
  logic      xfer;

  assign stream_stall = full;
  assign xfer         = stream_valid && !full;

  drle_front #(
    .SEGMENT_COUNT(SEGMENT_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .xfer        (xfer),
    .stream_byte (stream_byte),
    .cq          (cq)
  );

  drle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .cq         (cq),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  drle_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .kind          (kind),
    .write_address (write_address),
    .write_data    (write_data),
    .last          (last)
  );

endmodule

// ===== hw/rtl/drle_front.sv =====
// front end: parses the byte stream and turns each byte into at most one command
module drle_front #(
  parameter int SEGMENT_COUNT = drle_pkg::DEFAULT_SEGMENT_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  logic                xfer,
  input  logic [7:0]          stream_byte,
  output drle_pkg::cmd_push_t cq
);
  import drle_pkg::*;

  localparam int SEG_W = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;

  phase_t            phase, phase_next;
  logic [31:0]       dest_base;
  logic [SEG_W-1:0]  segment_index, segment_index_next;
  logic [1:0]        offset_byte_count, offset_byte_count_next;
  logic [23:0]       offset_accum, offset_accum_next;
  logic [31:0]       cursor_address, cursor_address_next;
  logic [7:0]        run_remaining, run_remaining_next;
  logic [2:0]        template_code, template_code_next;
  logic [2:0]        template_step, template_step_next;

  logic [6:0]  cur_inc;
  logic [2:0]  addr_off;
  logic [2:0]  step_inc;
  logic        tmpl_end;
  logic        last_seg;
  logic        is_end_code;
  logic        is_tmpl_code;

  assign step_inc     = template_step + 3'd1;
  assign tmpl_end     = (step_inc == tmpl_count(template_code));
  assign last_seg     = (segment_index == SEG_W'(SEGMENT_COUNT - 1));
  assign is_end_code  = (stream_byte == CODE_END);
  assign is_tmpl_code = (stream_byte <= CODE_TMPL_LAST);

  always_comb begin
    phase_next = phase;
    if (xfer) begin
      case (phase)
        PH_OFFSET: begin
          if (offset_byte_count == 2'd3) phase_next = PH_CONTROL;
        end
        PH_CONTROL: begin
          if (stream_byte[7]) begin
            phase_next = PH_LITERAL;
          end else if (stream_byte[6]) begin
            phase_next = PH_CONTROL;
          end else if (stream_byte[5]) begin
            phase_next = PH_REPEAT;
          end else if (stream_byte[4]) begin
            phase_next = PH_CONTROL;
          end else if (is_end_code || !is_tmpl_code) begin
            phase_next = last_seg ? PH_DONE : PH_OFFSET;
          end else begin
            phase_next = PH_TEMPLATE;
          end
        end
        PH_LITERAL: begin
          if (run_remaining == 8'd1) phase_next = PH_CONTROL;
        end
        PH_REPEAT: phase_next = PH_CONTROL;
        PH_TEMPLATE: begin
          if (tmpl_end) phase_next = PH_CONTROL;
        end
        PH_DONE: phase_next = PH_DONE;
        default: phase_next = PH_OFFSET;
      endcase
    end
  end

  always_comb begin
    segment_index_next     = segment_index;
    offset_byte_count_next = offset_byte_count;
    offset_accum_next      = offset_accum;
    run_remaining_next     = run_remaining;
    template_code_next     = template_code;
    template_step_next     = template_step;
    cur_inc                = '0;
    addr_off               = '0;
    cq.push                = 1'b0;
    cq.cmd.op              = CMD_RUN;
    cq.cmd.data            = stream_byte;
    cq.cmd.count           = RUN_W'(1);
    cq.cmd.alt             = 1'b0;
    cq.cmd.stream_end      = last_seg;
    if (xfer) begin
      case (phase)
        PH_OFFSET: begin
          offset_byte_count_next = offset_byte_count + 2'd1;
          offset_accum_next      = (offset_byte_count == 2'd3) ? 24'd0
                                   : {offset_accum[15:0], stream_byte};
        end
        PH_CONTROL: begin
          if (stream_byte[7]) begin
            run_remaining_next = {1'b0, stream_byte[6:0]} + 8'd1;
          end else if (stream_byte[6]) begin
            cur_inc = {1'b0, stream_byte[5:0]} + 7'd1;
          end else if (stream_byte[5]) begin
            run_remaining_next = {3'b000, stream_byte[4:0]} + 8'd2;
          end else if (stream_byte[4]) begin
            cq.push      = 1'b1;
            cq.cmd.data  = BYTE_FF;
            cq.cmd.count = RUN_W'({1'b0, stream_byte[3:0]}) + RUN_W'(1);
            cur_inc      = {3'b000, stream_byte[3:0]} + 7'd1;
          end else if (is_end_code || !is_tmpl_code) begin
            cq.push                = 1'b1;
            cq.cmd.op              = is_end_code ? CMD_END : CMD_BAD;
            segment_index_next     = segment_index + SEG_W'(1);
            offset_byte_count_next = '0;
            offset_accum_next      = '0;
          end else begin
            template_code_next = stream_byte[2:0];
            template_step_next = '0;
            cq.push            = 1'b1;
            cq.cmd.data        = BYTE_FF;
            // the constant bytes of a template go out with its code
            if (stream_byte[2:0] == TMPL_FF_PAIR) begin
              addr_off     = 3'd4;
              cq.cmd.count = RUN_W'(2);
            end else if (stream_byte[2:0] == TMPL_FF_ONE) begin
              addr_off     = 3'd4;
              cq.cmd.count = RUN_W'(1);
            end else begin
              cq.cmd.count = RUN_W'(2);
              cq.cmd.alt   = 1'b1;
            end
          end
        end
        PH_LITERAL: begin
          cq.push            = 1'b1;
          cur_inc            = 7'd1;
          run_remaining_next = run_remaining - 8'd1;
        end
        PH_REPEAT: begin
          cq.push            = 1'b1;
          cq.cmd.count       = run_remaining[RUN_W-1:0];
          cur_inc            = {1'b0, run_remaining[5:0]};
          run_remaining_next = '0;
        end
        PH_TEMPLATE: begin
          cq.push  = 1'b1;
          addr_off = tmpl_pos(template_code, template_step[1:0]);
          if (tmpl_end) begin
            cur_inc            = 7'd8;
            template_step_next = '0;
            template_code_next = '0;
          end else begin
            template_step_next = step_inc;
          end
        end
        default: ;
      endcase
    end
    cq.cmd.addr = cursor_address + {29'd0, addr_off};
    if (xfer && phase == PH_OFFSET && offset_byte_count == 2'd3) begin
      cursor_address_next = dest_base + {offset_accum, stream_byte};
    end else begin
      cursor_address_next = cursor_address + {25'd0, cur_inc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_OFFSET;
      dest_base         <= '0;
      segment_index     <= '0;
      offset_byte_count <= '0;
      offset_accum      <= '0;
      cursor_address    <= '0;
      run_remaining     <= '0;
      template_code     <= '0;
      template_step     <= '0;
    end else begin
      phase             <= phase_next;
      segment_index     <= segment_index_next;
      offset_byte_count <= offset_byte_count_next;
      offset_accum      <= offset_accum_next;
      cursor_address    <= cursor_address_next;
      run_remaining     <= run_remaining_next;
      template_code     <= template_code_next;
      template_step     <= template_step_next;
      if (cfg_wr_en) dest_base <= cfg_wr_data;
    end
  end

endmodule

// ===== hw/rtl/drle_queue.sv =====
// short command queue between the parser and the write expander
module drle_queue (
  input  logic                clk,
  input  logic                rst,
  input  drle_pkg::cmd_push_t cq,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output drle_pkg::cmd_t      head
);
  import drle_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill, fill_next;
  logic          do_push, do_pop;

  assign full       = (fill == CW'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = entry[rd_ptr];
  assign do_push    = cq.push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    fill_next = fill;
    if (do_push && !do_pop) fill_next = fill + CW'(1);
    else if (!do_push && do_pop) fill_next = fill - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (do_push) wr_ptr <= wr_ptr + QW'(1);
      if (do_pop) rd_ptr <= rd_ptr + QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= cq.cmd;
  end

endmodule

// ===== hw/rtl/drle_back.sv =====
// back end: expands queued commands into result items, one per cycle unless result_stall holds the output
module drle_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  drle_pkg::cmd_t head,
  output logic           pop,
  output logic           result_valid,
  input  logic           result_stall,
  output logic [1:0]     kind,
  output logic [31:0]    write_address,
  output logic [7:0]     write_data,
  output logic           last
);
  import drle_pkg::*;

  logic [RUN_W-1:0] idx;
  logic             load;
  logic             final_item;
  kind_t            kind_c;
  logic [31:0]      addr_c;
  logic [7:0]       data_c;

  assign load = !result_valid || !result_stall;
  assign pop  = head_valid && load && final_item;

  always_comb begin
    kind_c     = KIND_WRITE;
    addr_c     = '0;
    data_c     = '0;
    final_item = 1'b1;
    case (head.op)
      CMD_RUN: begin
        addr_c     = head.addr + {{(32-RUN_W){1'b0}}, idx};
        final_item = ((idx + RUN_W'(1)) == head.count);
        if (head.alt) data_c = (idx == '0) ? BYTE_A9 : BYTE_F0;
        else data_c = head.data;
      end
      CMD_END, CMD_BAD: begin
        // stream end marker trails the last segment's end
        if (idx == '0) begin
          kind_c     = (head.op == CMD_END) ? KIND_SEG_END : KIND_BAD;
          final_item = !head.stream_end;
        end else begin
          kind_c = KIND_STREAM_END;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      result_valid <= head_valid;
      if (head_valid) idx <= final_item ? '0 : idx + RUN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      kind          <= kind_c;
      write_address <= addr_c;
      write_data    <= data_c;
      last          <= final_item;
    end
  end

  a_run_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid && head.op == CMD_RUN |-> idx < head.count)
    else $error("run index past command length");

  a_marker_second_only_stream_end: assert property (@(posedge clk) disable iff (rst)
    head_valid && head.op != CMD_RUN && idx != '0 |-> head.stream_end && idx == RUN_W'(1))
    else $error("second marker item without stream end");

  a_stream_end_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_STREAM_END |-> last)
    else $error("stream end marker not flagged last");

  a_idx_clear_after_pop: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == '0)
    else $error("index not cleared after command retired");

endmodule
